/* rtl/core/bcd_tca_pkg.sv */
// Shared types and constants for the ten's complement BCD ALU.
package bcd_tca_pkg;

  localparam int unsigned DigitsDefault = 16;
  localparam int unsigned DataW         = 64;
  localparam int unsigned CountW        = 6;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_NEG   = 2'd2,
    OP_SHIFT = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [DataW-1:0]    operand_a;
    logic [DataW-1:0]    operand_b;
    logic [CountW-1:0]   shift_count;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             is_negative;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_ADD_AB,
    CMD_NEG_B,
    CMD_ADD_A_ACC,
    CMD_NEG_A,
    CMD_HALVE,
    CMD_ROUND,
    CMD_PUBLISH
  } dp_cmd_e;

  typedef struct packed {
    opcode_e in_opcode;
    logic    in_cnt_zero;
    logic    cnt_last;
    logic    out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_NEG_B,
    S_SUB_ADD,
    S_NEG_A,
    S_HALVE,
    S_ROUND,
    S_DONE
  } ctrl_state_e;

endpackage

/* rtl/core/bcd_tens_complement_alu_unit.sv */
// Top level of the ten's complement packed BCD ALU.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries opcode, two packed
// BCD operands (top digit is the sign, 0 or 9) and a halving count. Output
// channel out_valid_o / out_stall_i / out_data_o returns one result and its
// sign flag per input transfer, in order.
// One item is worked on at a time; a single shared decimal adder does every
// addition. Subtract negates b, then adds; a shift by n > 0 does one halving
// a cycle plus a rounding step; a shift by zero goes straight to the result.
// The next item is taken once the sequencer is back in idle after the result
// enters the output register, so a finished result may wait there while new
// work starts.
// A stalled result holds in the output register; the block then finishes the
// current item and waits with in_stall_o high until the register frees.
// Reset clears the sequencer and the output valid; no item is held.
module bcd_tens_complement_alu_unit #(
  parameter int unsigned DIGITS = bcd_tca_pkg::DigitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bcd_tca_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bcd_tca_pkg::out_item_t out_data_o
);

  bcd_tca_pkg::dp_cmd_e    cmd;
  bcd_tca_pkg::dp_status_t status;

  bcd_tca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  bcd_tca_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

`ifndef ASSERT_OFF
  a_sign_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_negative ==
                     (out_data_o.result_value[4*DIGITS-1 -: 4] == 4'h9)))
    else $error("sign flag does not match sign digit");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.result_value >> (4 * DIGITS)) == '0))
    else $error("result bits above the number are set");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in flight");
`endif

endmodule

/* rtl/core/bcd_tca_ctrl.sv */
// Sequencer for the ten's complement BCD ALU datapath.
module bcd_tca_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  bcd_tca_pkg::dp_status_t status_i,
  output bcd_tca_pkg::dp_cmd_e    cmd_o,
  output logic                    in_stall_o
);

  bcd_tca_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcd_tca_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = bcd_tca_pkg::CMD_IDLE;
    in_stall_o = 1'b1;
    unique case (state_q)
      bcd_tca_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o = bcd_tca_pkg::CMD_LOAD;
          unique case (status_i.in_opcode)
            bcd_tca_pkg::OP_ADD: state_d = bcd_tca_pkg::S_ADD;
            bcd_tca_pkg::OP_SUB: state_d = bcd_tca_pkg::S_NEG_B;
            bcd_tca_pkg::OP_NEG: state_d = bcd_tca_pkg::S_NEG_A;
            bcd_tca_pkg::OP_SHIFT: begin
              state_d = status_i.in_cnt_zero ? bcd_tca_pkg::S_DONE : bcd_tca_pkg::S_HALVE;
            end
            default: state_d = bcd_tca_pkg::S_IDLE;
          endcase
        end
      end
      bcd_tca_pkg::S_ADD: begin
        cmd_o   = bcd_tca_pkg::CMD_ADD_AB;
        state_d = bcd_tca_pkg::S_DONE;
      end
      bcd_tca_pkg::S_NEG_B: begin
        cmd_o   = bcd_tca_pkg::CMD_NEG_B;
        state_d = bcd_tca_pkg::S_SUB_ADD;
      end
      bcd_tca_pkg::S_SUB_ADD: begin
        cmd_o   = bcd_tca_pkg::CMD_ADD_A_ACC;
        state_d = bcd_tca_pkg::S_DONE;
      end
      bcd_tca_pkg::S_NEG_A: begin
        cmd_o   = bcd_tca_pkg::CMD_NEG_A;
        state_d = bcd_tca_pkg::S_DONE;
      end
      bcd_tca_pkg::S_HALVE: begin
        cmd_o = bcd_tca_pkg::CMD_HALVE;
        if (status_i.cnt_last) begin
          state_d = bcd_tca_pkg::S_ROUND;
        end
      end
      bcd_tca_pkg::S_ROUND: begin
        cmd_o   = bcd_tca_pkg::CMD_ROUND;
        state_d = bcd_tca_pkg::S_DONE;
      end
      bcd_tca_pkg::S_DONE: begin
        if (status_i.out_free) begin
          cmd_o   = bcd_tca_pkg::CMD_PUBLISH;
          state_d = bcd_tca_pkg::S_IDLE;
        end
      end
      default: state_d = bcd_tca_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/core/bcd_tca_datapath.sv */
// Operand registers, shared decimal adder, halving step and output register.
module bcd_tca_datapath #(
  parameter int unsigned DIGITS = bcd_tca_pkg::DigitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bcd_tca_pkg::in_item_t   in_data_i,
  input  bcd_tca_pkg::dp_cmd_e    cmd_i,
  output bcd_tca_pkg::dp_status_t status_o,
  output logic                    out_valid_o,
  output bcd_tca_pkg::out_item_t  out_data_o,
  input  logic                    out_stall_i
);

  localparam int unsigned W = bcd_tca_pkg::DataW;
  localparam int unsigned CW = bcd_tca_pkg::CountW;
  localparam logic [W-1:0] DigitMask = {W{1'b1}} >> (W - 4 * DIGITS);
  localparam logic [W-1:0] AllNines  = {(W/4){4'h9}} & DigitMask;
  localparam logic [W-1:0] One       = {{(W-1){1'b0}}, 1'b1};

  logic [W-1:0]  a_q, b_q, acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          spill_q, spill_d;
  logic          out_valid_q, out_valid_d;
  bcd_tca_pkg::out_item_t out_q, out_d;

  logic [3:0]    sign_digit;
  logic [W-1:0]  nines_a, nines_b;
  logic [W-1:0]  add_x, add_y, add_sum;
  logic [W-1:0]  halved;
  logic [DIGITS-1:0] gen, prop, cin;
  logic [DIGITS:0]   csum;
  logic [4:0]    s0 [DIGITS];
  logic [4:0]    t;
  logic [4:0]    rd;
  logic          upper_odd;

  assign sign_digit = acc_q[4*DIGITS-1 -: 4];

  // nine's complement of the operand digits
  always_comb begin
    nines_a = '0;
    nines_b = '0;
    for (int k = 0; k < DIGITS; k++) begin
      nines_a[4*k +: 4] = 4'h9 - a_q[4*k +: 4];
      nines_b[4*k +: 4] = 4'h9 - b_q[4*k +: 4];
    end
  end

  always_comb begin
    add_x = acc_q;
    add_y = One;
    unique case (cmd_i)
      bcd_tca_pkg::CMD_ADD_AB: begin
        add_x = a_q;
        add_y = b_q;
      end
      bcd_tca_pkg::CMD_NEG_B: begin
        add_x = nines_b;
        add_y = One;
      end
      bcd_tca_pkg::CMD_ADD_A_ACC: begin
        add_x = a_q;
        add_y = acc_q;
      end
      bcd_tca_pkg::CMD_NEG_A: begin
        add_x = nines_a;
        add_y = One;
      end
      bcd_tca_pkg::CMD_ROUND: begin
        add_x = acc_q;
        add_y = (sign_digit == 4'h0) ? One : AllNines;
      end
      default: begin
        add_x = acc_q;
        add_y = One;
      end
    endcase
  end

  // decimal adder: digit carries resolved by one binary carry chain
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      s0[k]   = {1'b0, add_x[4*k +: 4]} + {1'b0, add_y[4*k +: 4]};
      gen[k]  = (s0[k] > 5'd9);
      prop[k] = (s0[k] == 5'd9);
    end
    csum    = {1'b0, gen} + {1'b0, gen | prop};
    cin     = csum[DIGITS-1:0] ^ gen ^ (gen | prop);
    add_sum = '0;
    t       = '0;
    rd      = '0;
    for (int k = 0; k < DIGITS; k++) begin
      t  = s0[k] + {4'b0, cin[k]};
      rd = (t > 5'd9) ? (t - 5'd10) : t;
      add_sum[4*k +: 4] = rd[3:0];
    end
  end

  // one halving step; the sign digit stays
  always_comb begin
    halved    = acc_q;
    upper_odd = 1'b0;
    for (int k = 0; k < DIGITS - 1; k++) begin
      upper_odd = (k == DIGITS - 2) ? (sign_digit == 4'h9) : acc_q[4*(k+1)];
      halved[4*k +: 4] = {1'b0, acc_q[4*k+1 +: 3]} + (upper_odd ? 4'd5 : 4'd0);
    end
  end

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    spill_d     = spill_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (cmd_i)
      bcd_tca_pkg::CMD_LOAD: begin
        acc_d = in_data_i.operand_a & DigitMask;
        cnt_d = in_data_i.shift_count;
      end
      bcd_tca_pkg::CMD_ADD_AB, bcd_tca_pkg::CMD_NEG_B, bcd_tca_pkg::CMD_ADD_A_ACC,
      bcd_tca_pkg::CMD_NEG_A: begin
        acc_d = add_sum;
      end
      bcd_tca_pkg::CMD_HALVE: begin
        acc_d   = halved;
        spill_d = acc_q[0];
        cnt_d   = cnt_q - {{(CW-1){1'b0}}, 1'b1};
      end
      bcd_tca_pkg::CMD_ROUND: begin
        if (spill_q) begin
          acc_d = add_sum;
        end
      end
      bcd_tca_pkg::CMD_PUBLISH: begin
        out_d.result_value = acc_q;
        out_d.is_negative  = (sign_digit == 4'h9);
        out_valid_d        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == bcd_tca_pkg::CMD_LOAD) begin
      a_q <= in_data_i.operand_a;
      b_q <= in_data_i.operand_b;
    end
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
    spill_q <= spill_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.in_opcode   = in_data_i.opcode;
  assign status_o.in_cnt_zero = (in_data_i.shift_count == '0);
  assign status_o.cnt_last    = (cnt_q == {{(CW-1){1'b0}}, 1'b1});
  assign status_o.out_free    = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ten's complement packed BCD ALU.
module testbench;

  localparam int unsigned NDIG = bcd_tca_pkg::DigitsDefault;
  localparam int unsigned ITEMS = 900;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  bcd_tca_pkg::in_item_t  in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  bcd_tca_pkg::out_item_t out_data;

  bcd_tca_pkg::in_item_t  queued_ops[$];
  bcd_tca_pkg::out_item_t expected_results[$];
  int                     accepted_count = 0;
  int                     mismatch_count = 0;

  bcd_tens_complement_alu_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Decimal arithmetic on NDIG packed digits
  function automatic logic [63:0] dec_sum(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    logic [4:0]  s;
    logic        carry;
    r = '0;
    carry = 1'b0;
    for (int k = 0; k < NDIG; k++) begin
      s = {1'b0, x[4*k+:4]} + {1'b0, y[4*k+:4]} + {4'd0, carry};
      if (s > 5'd9) begin
        s = s - 5'd10;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      r[4*k+:4] = s[3:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] dec_negate(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < NDIG; k++) r[4*k+:4] = 4'd9 - x[4*k+:4];
    return dec_sum(r, 64'd1);
  endfunction

  function automatic logic [63:0] dec_halve(input logic [63:0] x, input logic [5:0] count);
    logic [63:0] t;
    logic [3:0]  d;
    logic [3:0]  spill;
    t = '0;
    spill = 4'd0;
    for (int k = 0; k < NDIG; k++) t[4*k+:4] = x[4*k+:4];
    if (count == 6'd0) return t;
    for (int n = 0; n < count; n++) begin
      spill = (t[4*(NDIG-1)+:4] == 4'd9) ? 4'd5 : 4'd0;
      for (int k = NDIG - 2; k >= 0; k--) begin
        d = t[4*k+:4];
        t[4*k+:4] = (d >> 1) + spill;
        spill = d[0] ? 4'd5 : 4'd0;
      end
    end
    if (spill != 4'd0) begin
      if (t[4*(NDIG-1)+:4] == 4'd0) t = dec_sum(t, 64'd1);
      else t = dec_sum(t, dec_negate(64'd1));
    end
    return t;
  endfunction

  function automatic bcd_tca_pkg::out_item_t predict_result(input bcd_tca_pkg::in_item_t it);
    bcd_tca_pkg::out_item_t o;
    case (it.opcode)
      bcd_tca_pkg::OP_ADD: o.result_value = dec_sum(it.operand_a, it.operand_b);
      bcd_tca_pkg::OP_SUB: o.result_value = dec_sum(it.operand_a, dec_negate(it.operand_b));
      bcd_tca_pkg::OP_NEG: o.result_value = dec_negate(it.operand_a);
      default:             o.result_value = dec_halve(it.operand_a, it.shift_count);
    endcase
    o.is_negative = (o.result_value[4*(NDIG-1)+:4] == 4'd9);
    return o;
  endfunction

  // Stimulus helpers
  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_bcd();
    logic [63:0] v;
    logic [3:0]  sign;
    int          len;
    sign = $urandom_range(0, 1) ? 4'd9 : 4'd0;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, NDIG - 1);
    v = rand_word();
    for (int k = 0; k < NDIG; k++)
      v[4*k+:4] = (k < len) ? 4'($urandom_range(0, 9)) : sign;
    return v;
  endfunction

  function automatic logic [63:0] pick_operand();
    return ($urandom_range(0, 9) == 0) ? rand_word() : rand_bcd();
  endfunction

  task automatic add_op(input bcd_tca_pkg::opcode_e op, input logic [63:0] a,
                        input logic [63:0] b, input logic [5:0] n);
    bcd_tca_pkg::in_item_t it;
    it.opcode = op;
    it.operand_a = a;
    it.operand_b = b;
    it.shift_count = n;
    queued_ops.push_back(it);
  endtask

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int idle_pct(input bit receiver);
    if (accepted_count < ITEMS / 3) return receiver ? 62 : 9;
    if (accepted_count < 2 * ITEMS / 3) return receiver ? 9 : 62;
    return 0;
  endfunction

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_data));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_ops.size() != 0 && !chance(idle_pct(1'b0))) begin
          in_valid <= 1'b1;
          in_data  <= queued_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    bcd_tca_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= chance(idle_pct(1'b1));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: %h / %b",
                     out_data.result_value, out_data.is_negative);
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_value !== want.result_value ||
              out_data.is_negative !== want.is_negative) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %h / %b, got %h / %b",
                       want.result_value, want.is_negative,
                       out_data.result_value, out_data.is_negative);
          end
        end
      end
    end
  end

  initial begin
    bcd_tca_pkg::opcode_e op;
    // Directed items
    add_op(bcd_tca_pkg::OP_ADD,   64'h0, 64'h0, 6'd0);
    add_op(bcd_tca_pkg::OP_ADD,   64'h0999_9999_9999_9999, 64'h1, 6'h3f);
    add_op(bcd_tca_pkg::OP_ADD,   64'h9999_9999_9999_9999, 64'h9999_9999_9999_9999, 6'd5);
    add_op(bcd_tca_pkg::OP_ADD,   64'h9000_0000_0000_0000, 64'h9000_0000_0000_0000, 6'd0);
    add_op(bcd_tca_pkg::OP_ADD,   64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 6'd0);
    add_op(bcd_tca_pkg::OP_SUB,   64'h0, 64'h0, 6'd0);
    add_op(bcd_tca_pkg::OP_SUB,   64'h5, 64'h7, 6'd9);
    add_op(bcd_tca_pkg::OP_SUB,   64'h9000_0000_0000_0000, 64'h0999_9999_9999_9999, 6'd0);
    add_op(bcd_tca_pkg::OP_SUB,   64'h0123_4567_8901_2345, 64'hffff_ffff_ffff_ffff, 6'h3f);
    add_op(bcd_tca_pkg::OP_NEG,   64'h0, 64'hffff_ffff_ffff_ffff, 6'h3f);
    add_op(bcd_tca_pkg::OP_NEG,   64'h9000_0000_0000_0000, 64'h0, 6'd0);
    add_op(bcd_tca_pkg::OP_NEG,   64'hffff_ffff_ffff_ffff, 64'h1234, 6'd1);
    add_op(bcd_tca_pkg::OP_NEG,   64'h0999_9999_9999_9999, 64'h0, 6'd0);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h0987_6543_2109_8765, 64'hffff_ffff_ffff_ffff, 6'd0);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'hdead_beef_cafe_f00d, 64'h0, 6'd0);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h7, 64'h0, 6'd1);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h9999_9999_9999_9993, 64'h0, 6'd1);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h0999_9999_9999_9999, 64'h0, 6'h3f);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h9999_9999_9999_9999, 64'h0, 6'h3f);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'hffff_ffff_ffff_ffff, 64'h0, 6'd2);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h1000_0000_0000_0001, 64'h0, 6'd1);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h9000_0000_0000_0000, 64'h0, 6'd4);
    add_op(bcd_tca_pkg::OP_SHIFT, 64'h0, 64'h0, 6'd7);
    // Random items, shifts mostly short
    for (int i = 0; i < ITEMS; i++) begin
      op = bcd_tca_pkg::opcode_e'($urandom_range(0, 3));
      add_op(op, pick_operand(), pick_operand(),
             chance(25) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6)));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (queued_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bcd_tca_pkg.sv
rtl/core/bcd_tca_ctrl.sv
rtl/core/bcd_tca_datapath.sv
rtl/core/bcd_tens_complement_alu_unit.sv
dv/testbench.sv
